[hdl/assert_macros.svh]
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst, a, c)
`define CHK_NEXT(label, clk, rst, a, c)
`endif
`endif

[hdl/ktwc_pkg.sv]
package ktwc_pkg;
  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned KEY_W = 29;
  localparam logic [9:0] SEG_MASK = 10'h3FF;
  localparam logic [7:0] ID_MASK = 8'hFF;
  localparam logic [1:0] SIDE_MASK = 2'h3;
  localparam int unsigned DET_SHIFT = 11;
  localparam int unsigned PLANE_SHIFT = 19;
  localparam int unsigned SIDE_SHIFT = 27;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_FWD = 2'd1;
  localparam logic [1:0] OP_REV = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [7:0] METHOD_NONE = 8'd0;
  localparam logic [7:0] METHOD_ISQRT = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_STORE, ST_SQRT, ST_DIV, ST_SUM, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [48:0] radicand;
    logic [47:0] dividend;
  } wk_req_t;

  typedef struct packed {
    logic done;
    logic [47:0] quotient;
  } wk_rsp_t;
endpackage

[hdl/ktwc_walk.sv]
// bit-serial square root then restoring division, two bits / one bit per cycle
module ktwc_walk
  import ktwc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  wk_req_t req,
  output wk_rsp_t rsp
);
  logic [49:0] rad;
  logic [25:0] root;
  logic [27:0] rem_s;
  logic [47:0] dvd;
  logic [48:0] rem_d;
  logic [5:0] cnt;
  logic phase;
  logic busy;
  logic [27:0] trial_s;
  logic [48:0] shift_d;

  assign trial_s = {rem_s[25:0], rad[49:48]} - {root, 2'b01};
  assign shift_d = {rem_d[47:0], dvd[47]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        phase <= 1'b0;
        cnt <= 6'd24;
        rad <= {1'b0, req.radicand};
        root <= '0;
        rem_s <= '0;
        dvd <= req.dividend;
        rem_d <= '0;
      end else if (busy && !phase) begin
        rad <= {rad[47:0], 2'b00};
        if (!trial_s[27]) begin
          rem_s <= trial_s;
          root <= {root[24:0], 1'b1};
        end else begin
          rem_s <= {rem_s[25:0], rad[49:48]};
          root <= {root[24:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          phase <= 1'b1;
          cnt <= 6'd47;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end else if (busy) begin
        dvd <= {dvd[46:0], 1'b0};
        if (shift_d >= {23'd0, root}) begin
          rem_d <= shift_d - {23'd0, root};
          rsp.quotient <= {rsp.quotient[46:0], 1'b1};
        end else begin
          rem_d <= shift_d;
          rsp.quotient <= {rsp.quotient[46:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end
endmodule

[hdl/keyed_time_walk_correction_top.sv]
// Keyed time-walk correction. Loads (operation 0) store a method, scale, pulse offset and
// time offset under a 29-bit channel key, replacing an entry with the same key or taking the
// first free slot, else flagging load_dropped. Forward/reverse items look the key up; with
// method 1 the time becomes t -/+ scale*2^16/floor(sqrt(|ph-offset|*2^16)) +/- time offset,
// saturated to 32 bits. One item at a time: the key search walks the table one entry per
// cycle, stopping early on a match, then method 1 runs the square root and then the division
// on the shared serial unit. A new transfer is taken only once the previous result has left.
// The table is a memory read at one address per cycle.
`include "assert_macros.svh"
module keyed_time_walk_correction_top
  import ktwc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         detector_id,
  input  logic [7:0]         plane_id,
  input  logic [9:0]         segment,
  input  logic [1:0]         end_side,
  input  logic signed [31:0] hit_time,
  input  logic signed [31:0] pulse_height,
  input  logic [7:0]         new_method,
  input  logic signed [31:0] new_scale,
  input  logic signed [31:0] new_pulse_offset,
  input  logic signed [31:0] new_time_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] corrected_time,
  output logic               hit,
  output logic               unknown_method,
  output logic               load_dropped
);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // table memory, one word per entry
  logic [KEY_W+8+96-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] vbits;
  logic [KEY_W+8+96-1:0] rd;

  state_t state, state_next;

  // captured item
  logic [1:0] op;
  logic [KEY_W-1:0] key;
  logic signed [31:0] t_in, ph_in;
  logic [7:0] l_method;
  logic [31:0] l_scale, l_poff, l_toff;

  logic [CW-1:0] scan;       // read address in flight, one ahead of data
  logic rd_ok;               // rd holds entry scan-1
  logic found, free_seen;
  logic [IW-1:0] slot, free_slot;
  logic [IW-1:0] prev_idx;

  wk_req_t wreq;
  wk_rsp_t wrsp;

  logic [7:0] e_method;
  logic [31:0] e_scale, e_poff, e_toff;
  logic [KEY_W-1:0] e_key;
  assign {e_key, e_method, e_scale, e_poff, e_toff} = rd;

  logic [33:0] diff;
  logic [32:0] dmag;
  logic [31:0] smag;
  assign diff = {{2{ph_in[31]}}, ph_in} - {{2{l_poff[31]}}, l_poff};
  assign dmag = diff[33] ? 33'(-diff) : diff[32:0];
  assign smag = l_scale[31] ? 32'(-l_scale) : l_scale;

  logic signed [49:0] m_s, sum;
  logic res_valid;

  // result fields for the item in hand
  logic signed [31:0] corrected_time_next;
  logic hit_next, unknown_method_next, load_dropped_next;

  ktwc_walk u_walk (.clk(clk), .rst(rst), .req(wreq), .rsp(wrsp));

  assign in_ready = (state == ST_IDLE) && !res_valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (rd_ok && vbits[prev_idx] && e_key == key) begin
          state_next = (op == OP_LOAD) ? ST_STORE : ST_OUT;
          if (op != OP_LOAD && e_method == METHOD_ISQRT) state_next = ST_SQRT;
        end else if (rd_ok && CW'(prev_idx) == CW'(ENTRIES - 1)) begin
          state_next = (op == OP_LOAD) ? ST_STORE : ST_OUT;
        end
        if (op == OP_NOP) state_next = ST_OUT;
      end
      ST_STORE: state_next = ST_OUT;
      ST_SQRT:  state_next = ST_DIV;
      ST_DIV:   if (wrsp.done) state_next = ST_SUM;
      ST_SUM:   state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // walk unit request
  always_comb begin
    wreq.start = (state == ST_SQRT);
    wreq.radicand = {((dmag == 33'd0) ? 33'd1 : dmag), 16'd0};
    wreq.dividend = {smag, 16'd0};
  end

  assign m_s = l_scale[31] ? -$signed({2'b00, wrsp.quotient}) : $signed({2'b00, wrsp.quotient});

  // result fields: loads report only the drop, no-ops report zero, misses pass the time
  always_comb begin
    corrected_time_next = '0;
    hit_next = 1'b0;
    unknown_method_next = 1'b0;
    load_dropped_next = 1'b0;
    if (op == OP_LOAD) begin
      load_dropped_next = !(found || free_seen);
    end else if (op != OP_NOP) begin
      hit_next = found;
      corrected_time_next = t_in;
      if (found && l_method == METHOD_ISQRT) begin
        if (sum > 50'sd2147483647) corrected_time_next = 32'h7FFFFFFF;
        else if (sum < -50'sd2147483648) corrected_time_next = 32'h80000000;
        else corrected_time_next = sum[31:0];
      end
      unknown_method_next = found && l_method != METHOD_NONE && l_method != METHOD_ISQRT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vbits <= '0;
      res_valid <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            op <= operation;
            key <= {end_side & SIDE_MASK, plane_id & ID_MASK, detector_id & ID_MASK,
                    1'b0, segment & SEG_MASK};
            t_in <= hit_time;
            ph_in <= pulse_height;
            l_method <= new_method;
            l_scale <= new_scale;
            l_poff <= new_pulse_offset;
            l_toff <= new_time_offset;
            scan <= '0;
            rd_ok <= 1'b0;
            found <= 1'b0;
            free_seen <= 1'b0;
          end
        end
        ST_SEARCH: begin
          if (scan < CW'(ENTRIES)) scan <= scan + CW'(1);
          rd_ok <= 1'b1;
          prev_idx <= scan[IW-1:0];
          if (rd_ok) begin
            if (vbits[prev_idx] && e_key == key) begin
              found <= 1'b1;
              slot <= prev_idx;
              if (op != OP_LOAD) begin
                l_method <= e_method;
                l_scale <= e_scale;
                l_poff <= e_poff;
                l_toff <= e_toff;
              end
            end else if (!vbits[prev_idx] && !free_seen) begin
              free_seen <= 1'b1;
              free_slot <= prev_idx;
            end
          end
        end
        ST_STORE: begin
          if (found || free_seen) vbits[found ? slot : free_slot] <= 1'b1;
        end
        ST_SUM: begin
          if (op == OP_FWD)
            sum <= 50'(t_in) - m_s + 50'($signed(l_toff));
          else
            sum <= 50'(t_in) + m_s - 50'($signed(l_toff));
        end
        ST_OUT: begin
          res_valid <= 1'b1;
          load_dropped <= load_dropped_next;
          hit <= hit_next;
          unknown_method <= unknown_method_next;
          corrected_time <= corrected_time_next;
        end
        default: ;
      endcase
    end
  end

  // memory port: one read per cycle during the search, one write at store
  always_ff @(posedge clk) begin
    rd <= mem[scan[IW-1:0]];
    if (state == ST_STORE && (found || free_seen))
      mem[found ? slot : free_slot] <= {key, l_method, l_scale, l_poff, l_toff};
  end

  assign out_valid = res_valid;

  // checks
  `CHK_IMPL(a_no_accept_busy, clk, rst, state != ST_IDLE, !in_ready)
  `CHK_NEXT(a_out_after_done, clk, rst, state == ST_OUT, out_valid)
  `CHK_IMPL(a_walk_only_div, clk, rst, wrsp.done, state == ST_DIV)
endmodule

[tb/keyed_time_walk_correction_top_tb.sv]
`timescale 1ns / 1ps
module keyed_time_walk_correction_top_tb
  import ktwc_pkg::*;
();

  localparam int unsigned N_SLOTS = ENTRIES_DEF;
  localparam longint CYCLE_LIMIT = 64'd2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0, in_ready;
  logic [1:0] operation = '0;
  logic [7:0] detector_id = '0, plane_id = '0, new_method = '0;
  logic [9:0] segment = '0;
  logic [1:0] end_side = '0;
  logic signed [31:0] hit_time = '0, pulse_height = '0;
  logic signed [31:0] new_scale = '0, new_pulse_offset = '0, new_time_offset = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] corrected_time;
  logic hit, unknown_method, load_dropped;

  keyed_time_walk_correction_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one input item, as presented on the ports
  typedef struct {
    logic [1:0] op;
    logic [7:0] det, plane, method;
    logic [9:0] seg;
    logic [1:0] side;
    logic signed [31:0] t, ph, scale, poff, toff;
  } hit_item_t;

  typedef struct {
    logic signed [31:0] time_q12;
    logic hit, unknown, dropped;
  } correction_t;

  // shadow of the channel table
  logic [28:0] chan_key[N_SLOTS];
  logic chan_used[N_SLOTS];
  logic [7:0] chan_method[N_SLOTS];
  logic signed [31:0] chan_scale[N_SLOTS], chan_poff[N_SLOTS], chan_toff[N_SLOTS];

  correction_t pending_corrections[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cycle_count = 0;

  // keys already loaded, so corrections mostly hit
  logic [28:0] known_keys[$];

  function automatic logic [28:0] channel_key(hit_item_t it);
    return (29'(it.det) << DET_SHIFT) | (29'(it.plane) << PLANE_SHIFT) |
           29'(it.seg) | (29'(it.side) << SIDE_SHIFT);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] saturate(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int find_slot(logic [28:0] k);
    for (int i = 0; i < N_SLOTS; i++)
      if (chan_used[i] && chan_key[i] == k) return i;
    return -1;
  endfunction

  // predicted result of one item, updating the shadow table
  function automatic correction_t predict_correction(hit_item_t it);
    correction_t r;
    logic [28:0] k;
    int s;
    longint diff, sc, m, tsum;
    logic [63:0] d, mag, root, q;
    r = '{default: '0};
    k = channel_key(it);
    if (it.op == OP_LOAD) begin
      s = find_slot(k);
      if (s < 0)
        for (int i = 0; i < N_SLOTS; i++)
          if (!chan_used[i]) begin
            s = i;
            break;
          end
      if (s < 0) begin
        r.dropped = 1'b1;
      end else begin
        chan_used[s] = 1'b1;
        chan_key[s] = k;
        chan_method[s] = it.method;
        chan_scale[s] = it.scale;
        chan_poff[s] = it.poff;
        chan_toff[s] = it.toff;
      end
      return r;
    end
    if (it.op == OP_NOP) return r;
    s = find_slot(k);
    r.time_q12 = it.t;
    if (s < 0) return r;
    r.hit = 1'b1;
    if (chan_method[s] == METHOD_ISQRT) begin
      diff = longint'(it.ph) - longint'(chan_poff[s]);
      d = diff < 0 ? -diff : diff;
      if (d == 0) d = 1;
      sc = chan_scale[s];
      mag = sc < 0 ? -sc : sc;
      root = int_sqrt(d << 16);
      q = (mag << 16) / root;
      m = sc < 0 ? -longint'(q) : longint'(q);
      if (it.op == OP_FWD) tsum = longint'(it.t) - m + longint'(chan_toff[s]);
      else tsum = longint'(it.t) + m - longint'(chan_toff[s]);
      r.time_q12 = saturate(tsum);
    end else if (chan_method[s] != METHOD_NONE) begin
      r.unknown = 1'b1;
    end
    return r;
  endfunction

  // drive one item, sometimes after an idle gap, and wait for its transfer
  task automatic send_item(hit_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    operation <= it.op;
    detector_id <= it.det;
    plane_id <= it.plane;
    segment <= it.seg;
    end_side <= it.side;
    hit_time <= it.t;
    pulse_height <= it.ph;
    new_method <= it.method;
    new_scale <= it.scale;
    new_pulse_offset <= it.poff;
    new_time_offset <= it.toff;
    do @(posedge clk); while (!in_ready);
    pending_corrections.push_back(predict_correction(it));
    if (it.op == OP_LOAD) known_keys.push_back(channel_key(it));
  endtask

  function automatic hit_item_t random_item(logic [1:0] op);
    hit_item_t it;
    logic [28:0] k;
    it.op = op;
    it.det = 8'($urandom); it.plane = 8'($urandom);
    it.seg = 10'($urandom); it.side = 2'($urandom);
    it.t = $urandom; it.ph = $urandom; it.method = 8'($urandom);
    it.scale = $urandom; it.poff = $urandom; it.toff = $urandom;
    // mostly well-formed: valid methods, keys that are known, modest values
    if ($urandom_range(9) < 8) it.method = $urandom_range(1) ? METHOD_ISQRT : METHOD_NONE;
    if ($urandom_range(3) != 0) begin
      it.t = $signed($urandom_range(2000000)) - 1000000;
      it.scale = $signed($urandom_range(200000)) - 100000;
      it.toff = $signed($urandom_range(40000)) - 20000;
    end
    if (op != OP_LOAD && known_keys.size() > 0 && $urandom_range(9) < 8) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
      it.seg = k[9:0]; it.det = k[18:11]; it.plane = k[26:19]; it.side = k[28:27];
    end
    return it;
  endfunction

  function automatic hit_item_t keyed_item(logic [1:0] op, logic [7:0] det, logic [9:0] seg);
    hit_item_t it;
    it = '{op: op, det: det, plane: 8'd0, seg: seg, side: 2'd0, default: '0};
    return it;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_corrections.size() != 0);
  endtask

  // result checker
  always @(posedge clk) begin
    correction_t e;
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (pending_corrections.size() == 0) begin
          $display("%0t: unexpected result time=%0d", $time, corrected_time);
          errors++;
        end else begin
          e = pending_corrections.pop_front();
          if (corrected_time !== e.time_q12) begin
            $display("%0t: corrected_time exp %0d got %0d", $time, e.time_q12, corrected_time);
            errors++;
          end
          if (hit !== e.hit) begin
            $display("%0t: hit exp %0b got %0b", $time, e.hit, hit);
            errors++;
          end
          if (unknown_method !== e.unknown) begin
            $display("%0t: unknown_method exp %0b got %0b", $time, e.unknown, unknown_method);
            errors++;
          end
          if (load_dropped !== e.dropped) begin
            $display("%0t: load_dropped exp %0b got %0b", $time, e.dropped, load_dropped);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // extremes of fields, misses, every method, zero distance, saturation
  task automatic test_directed();
    hit_item_t it;
    send_item(keyed_item(OP_FWD, 8'd1, 10'd1));  // miss on empty table
    it = keyed_item(OP_LOAD, 8'hFF, 10'h3FF);
    it.plane = 8'hFF; it.side = 2'd3; it.method = METHOD_ISQRT;
    it.scale = 32'sh7FFFFFFF; it.poff = 32'sh80000000; it.toff = 32'sh7FFFFFFF;
    send_item(it);
    it.op = OP_FWD; it.t = 32'sh80000000; it.ph = 32'sh80000000;  // zero distance
    send_item(it);
    it.op = OP_REV; it.t = 32'sh7FFFFFFF;  // saturates high
    send_item(it);
    it.ph = 32'sh7FFFFFFF;
    send_item(it);
    it.side = 2'd1;  // differs from the loaded key only in the upper side bit
    send_item(it);
    it = keyed_item(OP_LOAD, 8'd2, 10'd0);
    it.method = METHOD_ISQRT; it.scale = 32'sh80000000; it.poff = 32'sd65536;
    it.toff = 32'sh80000000;
    send_item(it);
    it.op = OP_FWD; it.t = 32'sh7FFFFFFF; it.ph = 32'sd0;
    send_item(it);
    it.op = OP_REV; it.t = 32'sh80000000;
    send_item(it);
    it = keyed_item(OP_LOAD, 8'd3, 10'd5);
    it.method = METHOD_NONE;
    send_item(it);
    it.op = OP_FWD; it.t = 32'sd12345;
    send_item(it);
    it = keyed_item(OP_LOAD, 8'd3, 10'd5);  // overwrite same key
    it.method = 8'hFF;
    send_item(it);
    it.op = OP_REV; it.t = -32'sd777;
    send_item(it);
    it = keyed_item(OP_NOP, 8'd3, 10'd5);
    it.t = 32'sd99;
    send_item(it);
    send_item(keyed_item(OP_REV, 8'd3, 10'd5));
  endtask

  // fill the table until loads are dropped, then hit the full table
  task automatic test_table_full();
    hit_item_t it;
    for (int i = 0; i < N_SLOTS + 4; i++) begin
      it = random_item(OP_LOAD);
      send_item(it);
    end
    for (int i = 0; i < 20; i++) send_item(random_item(2'($urandom_range(1, 2))));
    it = random_item(OP_LOAD);
    it.det = known_keys[0][18:11]; it.seg = known_keys[0][9:0];
    it.plane = known_keys[0][26:19]; it.side = known_keys[0][28:27];
    send_item(it);  // existing key still replaced when full
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(9) == 0 ? 2'($urandom_range(3)) : 2'($urandom_range(1, 2));
      send_item(random_item(op));
    end
  endtask

  initial begin
    for (int i = 0; i < N_SLOTS; i++) chan_used[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();  // sender holds off until everything is back
    test_table_full();
    test_random(300);
    send_idle_pct = 85;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 85;
    test_random(300);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_corrections.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
